FILE: rtl/rco_pkg.sv
// Shared types and constants for the Rossler oscillator block.
// Depends on nothing; every other file in rtl imports it.
`timescale 1ns / 1ps

package rco_pkg;

    localparam int STATE_W      = 32;
    localparam int DT_W         = 24;
    localparam int AMP_W        = 16;
    localparam int SCALE_W      = 20;
    localparam int Q24_FRAC_BITS = 24;
    localparam int AMP_FRAC_BITS = 15;

    localparam int MUL_B_W = STATE_W + 1;
    localparam int PROD_W  = STATE_W + MUL_B_W;
    localparam int OPND_W  = STATE_W + 2;
    localparam int ALU_W   = PROD_W + 1;

    localparam int CFG_W     = DT_W;
    localparam int CFG_IDX_W = 2;

    // Output scales in unsigned Q0.24.
    localparam logic [SCALE_W-1:0] SCALE_LEFT  = 20'd965864;
    localparam logic [SCALE_W-1:0] SCALE_RIGHT = 20'd1011331;

    localparam logic [DT_W-1:0]  STEP_SIZE_RESET = 24'd443;
    localparam logic [AMP_W-1:0] AMPLITUDE_RESET = 16'd16384;
    localparam logic             MONO_RESET      = 1'b0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP_SIZE = 2'd0,
        CFG_AMPLITUDE = 2'd1,
        CFG_MONO_MODE = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        SH_STATE = 2'd0,
        SH_Q24   = 2'd1,
        SH_AMP   = 2'd2
    } shift_sel_t;

    typedef struct packed {
        logic       use_prod;
        shift_sel_t shift;
        logic       sat_sample;
    } alu_ctl_t;

    typedef enum logic [11:0] {
        ST_IDLE  = 12'b0000_0000_0001,
        ST_XC    = 12'b0000_0000_0010,
        ST_DX    = 12'b0000_0000_0100,
        ST_DZ    = 12'b0000_0000_1000,
        ST_DY    = 12'b0000_0001_0000,
        ST_X     = 12'b0000_0010_0000,
        ST_Z     = 12'b0000_0100_0000,
        ST_Y     = 12'b0000_1000_0000,
        ST_TL    = 12'b0001_0000_0000,
        ST_TR    = 12'b0010_0000_0000,
        ST_LEFT  = 12'b0100_0000_0000,
        ST_RIGHT = 12'b1000_0000_0000
    } state_t;

endpackage

FILE: rtl/rco_mult.sv
// Shared signed multiplier with a registered product.
// Depends on rco_pkg for the operand and product widths.
`timescale 1ns / 1ps

module rco_mult (
    input  logic                                clk,
    input  logic                                issue,
    input  logic signed [rco_pkg::STATE_W-1:0]  mul_a,
    input  logic signed [rco_pkg::MUL_B_W-1:0]  mul_b,
    output logic signed [rco_pkg::PROD_W-1:0]   prod
);
    import rco_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;

    // The product only changes when a new operation is issued, so a
    // waiting sequencer can keep consuming the last one.
    always_comb
    begin
        prod_next = prod_reg;
        if (issue)
        begin
            prod_next = mul_a * mul_b;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

FILE: rtl/rco_alu.sv
// Shared post-multiply unit: round-to-nearest shift, add, saturate.
// Depends on rco_pkg for widths and the control struct.
`timescale 1ns / 1ps

module rco_alu #(
    parameter int STATE_FRAC_BITS = 24,
    parameter int SAMPLE_WIDTH    = 16
) (
    input  rco_pkg::alu_ctl_t                  ctl,
    input  logic signed [rco_pkg::PROD_W-1:0]  prod,
    input  logic signed [rco_pkg::OPND_W-1:0]  opnd_a,
    input  logic signed [rco_pkg::OPND_W-1:0]  opnd_b,
    output logic signed [rco_pkg::STATE_W-1:0] result
);
    import rco_pkg::*;

    localparam int SH_S = STATE_FRAC_BITS;
    localparam int SH_D = Q24_FRAC_BITS;
    localparam int SH_A = STATE_FRAC_BITS + AMP_FRAC_BITS + 1 - SAMPLE_WIDTH;

    localparam logic signed [ALU_W-1:0] BIAS_S = ALU_W'(1) << (SH_S - 1);
    localparam logic signed [ALU_W-1:0] BIAS_D = ALU_W'(1) << (SH_D - 1);
    localparam logic signed [ALU_W-1:0] BIAS_A = ALU_W'(1) << (SH_A - 1);

    localparam logic signed [ALU_W-1:0] S32_MAX  = ALU_W'((longint'(1) << (STATE_W - 1)) - 1);
    localparam logic signed [ALU_W-1:0] S32_MIN  = -S32_MAX - ALU_W'(1);
    localparam logic signed [ALU_W-1:0] SAMP_MAX =
        ALU_W'((longint'(1) << (SAMPLE_WIDTH - 1)) - 1);
    localparam logic signed [ALU_W-1:0] SAMP_MIN = -SAMP_MAX - ALU_W'(1);

    logic signed [ALU_W-1:0] prod_ext;
    logic signed [ALU_W-1:0] bias;
    logic signed [ALU_W-1:0] biased;
    logic signed [ALU_W-1:0] term;
    logic signed [ALU_W-1:0] a_ext;
    logic signed [ALU_W-1:0] b_ext;
    logic signed [ALU_W-1:0] sum;
    logic signed [ALU_W-1:0] lim_hi;
    logic signed [ALU_W-1:0] lim_lo;
    logic signed [ALU_W-1:0] sat;

    assign prod_ext = {{(ALU_W - PROD_W){prod[PROD_W-1]}}, prod};
    assign a_ext    = {{(ALU_W - OPND_W){opnd_a[OPND_W-1]}}, opnd_a};
    assign b_ext    = {{(ALU_W - OPND_W){opnd_b[OPND_W-1]}}, opnd_b};

    always_comb
    begin
        unique case (ctl.shift)
            SH_STATE: bias = BIAS_S;
            SH_Q24:   bias = BIAS_D;
            SH_AMP:   bias = BIAS_A;
            default:  bias = BIAS_D;
        endcase
    end

    // Adding half an LSB before the arithmetic shift rounds ties upward.
    assign biased = prod_ext + bias;

    always_comb
    begin
        unique case (ctl.shift)
            SH_STATE: term = biased >>> SH_S;
            SH_Q24:   term = biased >>> SH_D;
            SH_AMP:   term = biased >>> SH_A;
            default:  term = biased >>> SH_D;
        endcase
    end

    assign sum    = a_ext + (ctl.use_prod ? term : b_ext);
    assign lim_hi = ctl.sat_sample ? SAMP_MAX : S32_MAX;
    assign lim_lo = ctl.sat_sample ? SAMP_MIN : S32_MIN;

    always_comb
    begin
        if (sum > lim_hi)
        begin
            sat = lim_hi;
        end
        else if (sum < lim_lo)
        begin
            sat = lim_lo;
        end
        else
        begin
            sat = sum;
        end
    end

    assign result = sat[STATE_W-1:0];

endmodule

FILE: rtl/rossler_chaotic_oscillator.sv
// Rossler attractor oscillator: one forward-Euler step and one stereo
// sample pair per input item. Depends on rco_pkg, rco_mult and rco_alu.
//
// Input channel (in_valid, in_stall, restart): each accepted item is one
// sample tick; restart reloads x = y = z = 1.0 before the step. The block
// holds in_stall high from the cycle after acceptance until its sequencer
// is back in idle, so a new item is not taken before the last is done.
// Output channel (out_valid, out_stall, left_sample, right_sample): the
// pair is loaded into the output register when the last step completes.
// The step runs 11 sequencer steps through one registered 32x33
// multiplier and one round/add/saturate unit. If the previous pair is
// still stalled when the last step is reached, the sequencer waits there
// and the input stays stalled. Configuration (cfg_write_en, cfg_index,
// cfg_data) is to be written by the user only while idle; the block
// does not enforce this. Reset loads the state with 1.0, the registers
// with their defaults, and empties the output register.
`timescale 1ns / 1ps

module rossler_chaotic_oscillator #(
    parameter int STATE_FRAC_BITS = 24,
    parameter int SAMPLE_WIDTH    = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                restart,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [SAMPLE_WIDTH-1:0]      left_sample,
    output logic signed [SAMPLE_WIDTH-1:0]      right_sample,
    input  logic                                cfg_write_en,
    input  logic [rco_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rco_pkg::CFG_W-1:0]           cfg_data
);
    import rco_pkg::*;

    localparam logic signed [STATE_W-1:0] POS_ONE =
        STATE_W'(longint'(1) << STATE_FRAC_BITS);
    localparam longint KA_VAL = ((longint'(15) << STATE_FRAC_BITS) + 50) / 100;
    localparam longint KB_VAL = ((longint'(2) << STATE_FRAC_BITS) + 5) / 10;
    localparam longint KC_VAL = longint'(10) << STATE_FRAC_BITS;
    localparam logic signed [MUL_B_W-1:0] KA_OPND = MUL_B_W'(KA_VAL);
    localparam logic signed [OPND_W-1:0]  KB_OPND = OPND_W'(KB_VAL);
    localparam logic signed [OPND_W-1:0]  NEG_KC  = OPND_W'(-KC_VAL);

    function automatic logic signed [OPND_W-1:0] sx(input logic signed [STATE_W-1:0] v);
        return {{(OPND_W - STATE_W){v[STATE_W-1]}}, v};
    endfunction

    state_t state_reg;
    state_t state_next;

    logic signed [STATE_W-1:0] pos_x_reg;
    logic signed [STATE_W-1:0] pos_y_reg;
    logic signed [STATE_W-1:0] pos_z_reg;
    // xc_reg later holds the left scaled value, dx_reg the right one.
    logic signed [STATE_W-1:0] xc_reg;
    logic signed [STATE_W-1:0] dx_reg;
    logic signed [STATE_W-1:0] dy_reg;
    logic signed [STATE_W-1:0] dz_reg;

    logic [DT_W-1:0]  step_size_reg;
    logic [AMP_W-1:0] amplitude_reg;
    logic             mono_mode_reg;

    logic signed [SAMPLE_WIDTH-1:0] left_hold_reg;
    logic signed [SAMPLE_WIDTH-1:0] left_sample_reg;
    logic signed [SAMPLE_WIDTH-1:0] right_sample_reg;
    logic                           out_valid_reg;

    logic                        in_accept;
    logic                        out_free;
    logic                        mul_issue;
    logic signed [STATE_W-1:0]   mul_a;
    logic signed [MUL_B_W-1:0]   mul_b;
    logic signed [PROD_W-1:0]    mul_prod;
    alu_ctl_t                    alu_ctl;
    logic signed [OPND_W-1:0]    alu_a;
    logic signed [OPND_W-1:0]    alu_b;
    logic signed [STATE_W-1:0]   alu_result;
    logic signed [MUL_B_W-1:0]   dt_opnd;
    logic signed [MUL_B_W-1:0]   amp_opnd;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign dt_opnd   = {{(MUL_B_W - DT_W){1'b0}}, step_size_reg};
    assign amp_opnd  = {{(MUL_B_W - AMP_W){1'b0}}, amplitude_reg};

    rco_mult u_mult (
        .clk   (clk),
        .issue (mul_issue),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .prod  (mul_prod)
    );

    rco_alu #(
        .STATE_FRAC_BITS (STATE_FRAC_BITS),
        .SAMPLE_WIDTH    (SAMPLE_WIDTH)
    ) u_alu (
        .ctl    (alu_ctl),
        .prod   (mul_prod),
        .opnd_a (alu_a),
        .opnd_b (alu_b),
        .result (alu_result)
    );

    // Each step from ST_DZ on consumes the product issued in the step before it.
    always_comb
    begin
        mul_issue = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        alu_ctl   = '{use_prod: 1'b1, shift: SH_Q24, sat_sample: 1'b0};
        alu_a     = '0;
        alu_b     = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
            end
            ST_XC:
            begin
                alu_ctl.use_prod = 1'b0;
                alu_a            = sx(pos_x_reg);
                alu_b            = NEG_KC;
            end
            ST_DX:
            begin
                alu_ctl.use_prod = 1'b0;
                alu_a            = -sx(pos_y_reg);
                alu_b            = -sx(pos_z_reg);
                mul_issue        = 1'b1;
                mul_a            = xc_reg;
                mul_b            = {pos_z_reg[STATE_W-1], pos_z_reg};
            end
            ST_DZ:
            begin
                alu_ctl.shift = SH_STATE;
                alu_a         = KB_OPND;
                mul_issue     = 1'b1;
                mul_a         = pos_y_reg;
                mul_b         = KA_OPND;
            end
            ST_DY:
            begin
                alu_ctl.shift = SH_STATE;
                alu_a         = sx(pos_x_reg);
                mul_issue     = 1'b1;
                mul_a         = dx_reg;
                mul_b         = dt_opnd;
            end
            ST_X:
            begin
                alu_a     = sx(pos_x_reg);
                mul_issue = 1'b1;
                mul_a     = dz_reg;
                mul_b     = dt_opnd;
            end
            ST_Z:
            begin
                alu_a     = sx(pos_z_reg);
                mul_issue = 1'b1;
                mul_a     = dy_reg;
                mul_b     = dt_opnd;
            end
            ST_Y:
            begin
                alu_a     = sx(pos_y_reg);
                mul_issue = 1'b1;
                mul_a     = pos_x_reg;
                mul_b     = {{(MUL_B_W - SCALE_W){1'b0}}, SCALE_LEFT};
            end
            ST_TL:
            begin
                mul_issue = 1'b1;
                mul_a     = pos_y_reg;
                mul_b     = {{(MUL_B_W - SCALE_W){1'b0}}, SCALE_RIGHT};
            end
            ST_TR:
            begin
                mul_issue = 1'b1;
                mul_a     = xc_reg;
                mul_b     = amp_opnd;
            end
            ST_LEFT:
            begin
                alu_ctl.shift      = SH_AMP;
                alu_ctl.sat_sample = 1'b1;
                mul_issue          = 1'b1;
                mul_a              = dx_reg;
                mul_b              = amp_opnd;
            end
            ST_RIGHT:
            begin
                alu_ctl.shift      = SH_AMP;
                alu_ctl.sat_sample = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  state_next = in_accept ? ST_XC : ST_IDLE;
            ST_XC:    state_next = ST_DX;
            ST_DX:    state_next = ST_DZ;
            ST_DZ:    state_next = ST_DY;
            ST_DY:    state_next = ST_X;
            ST_X:     state_next = ST_Z;
            ST_Z:     state_next = ST_Y;
            ST_Y:     state_next = ST_TL;
            ST_TL:    state_next = ST_TR;
            ST_TR:    state_next = ST_LEFT;
            ST_LEFT:  state_next = ST_RIGHT;
            ST_RIGHT: state_next = out_free ? ST_IDLE : ST_RIGHT;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_x_reg     <= POS_ONE;
            pos_y_reg     <= POS_ONE;
            pos_z_reg     <= POS_ONE;
            step_size_reg <= STEP_SIZE_RESET;
            amplitude_reg <= AMPLITUDE_RESET;
            mono_mode_reg <= MONO_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (in_accept && restart)
            begin
                pos_x_reg <= POS_ONE;
                pos_y_reg <= POS_ONE;
                pos_z_reg <= POS_ONE;
            end
            if (state_reg == ST_X)
            begin
                pos_x_reg <= alu_result;
            end
            if (state_reg == ST_Z)
            begin
                pos_z_reg <= alu_result;
            end
            if (state_reg == ST_Y)
            begin
                pos_y_reg <= alu_result;
            end

            if (cfg_write_en)
            begin
                unique case (cfg_index)
                    CFG_STEP_SIZE: step_size_reg <= cfg_data[DT_W-1:0];
                    CFG_AMPLITUDE: amplitude_reg <= cfg_data[AMP_W-1:0];
                    CFG_MONO_MODE: mono_mode_reg <= cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end

            if (state_reg == ST_RIGHT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_XC || state_reg == ST_TL)
        begin
            xc_reg <= alu_result;
        end
        if (state_reg == ST_DX || state_reg == ST_TR)
        begin
            dx_reg <= alu_result;
        end
        if (state_reg == ST_DZ)
        begin
            dz_reg <= alu_result;
        end
        if (state_reg == ST_DY)
        begin
            dy_reg <= alu_result;
        end
        if (state_reg == ST_LEFT)
        begin
            left_hold_reg <= alu_result[SAMPLE_WIDTH-1:0];
        end
        if (state_reg == ST_RIGHT && out_free)
        begin
            left_sample_reg  <= left_hold_reg;
            right_sample_reg <= mono_mode_reg ? left_hold_reg
                                              : alu_result[SAMPLE_WIDTH-1:0];
        end
    end

    assign out_valid    = out_valid_reg;
    assign left_sample  = left_sample_reg;
    assign right_sample = right_sample_reg;

`ifndef NO_ASSERTIONS
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> state_reg == ST_XC)
        else $error("accepted item did not start the sequencer");

    a_out_from_last_step: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_RIGHT))
        else $error("output item appeared without finishing a step");

    a_wait_holds_product: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RIGHT && !out_free) |=>
            (state_reg == ST_RIGHT && $stable(mul_prod)))
        else $error("product changed while waiting on a stalled output");
`endif

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for the Rossler oscillator block: drives sample ticks with
// random gaps and output stalls, and predicts every stereo pair from an internal orbit.
// Depends on rco_pkg and rossler_chaotic_oscillator.
`timescale 1ns / 1ps

module testbench;

    import rco_pkg::*;

    localparam int SAMPLE_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam longint STATE_ONE = longint'(1) <<< Q24_FRAC_BITS;
    localparam longint K_A = ((longint'(15) <<< Q24_FRAC_BITS) + 50) / 100;
    localparam longint K_B = ((longint'(2) <<< Q24_FRAC_BITS) + 5) / 10;
    localparam longint K_C = longint'(10) <<< Q24_FRAC_BITS;
    localparam longint S32_MIN = -(longint'(1) <<< 31);
    localparam longint S32_MAX = (longint'(1) <<< 31) - 1;
    localparam longint SAMPLE_MIN = -(longint'(1) <<< (SAMPLE_W - 1));
    localparam longint SAMPLE_MAX = (longint'(1) <<< (SAMPLE_W - 1)) - 1;

    typedef struct {
        logic [SAMPLE_W-1:0] left;
        logic [SAMPLE_W-1:0] right;
    } stereo_pair_t;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    logic                          restart;
    logic                          out_valid;
    logic                          out_stall;
    logic signed [SAMPLE_W-1:0]    left_sample;
    logic signed [SAMPLE_W-1:0]    right_sample;
    logic                          cfg_write_en;
    logic [CFG_IDX_W-1:0]          cfg_index;
    logic [CFG_W-1:0]              cfg_data;

    // Predicted orbit and register copies.
    longint          orb_x;
    longint          orb_y;
    longint          orb_z;
    logic [DT_W-1:0] dt_reg;
    logic [15:0]     gain_reg;
    logic            mono_reg;

    stereo_pair_t pending_pairs[$];

    int gap_pct;
    int stall_pct;
    int ticks_sent;
    int restarts_sent;
    int pairs_checked;
    int mismatch_count;
    int settings_used;
    int rail_hits;
    int drain_cycles;

    rossler_chaotic_oscillator i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .restart      (restart),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .left_sample  (left_sample),
        .right_sample (right_sample),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    function automatic longint clamp32(longint v);
        if (v < S32_MIN)
            return S32_MIN;
        if (v > S32_MAX)
            return S32_MAX;
        return v;
    endfunction

    // Arithmetic shift after adding half an LSB: round to nearest, ties upward.
    function automatic longint rnd_shift(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic logic [SAMPLE_W-1:0] to_sample(longint pos, longint scale);
        longint t;
        longint s;
        t = rnd_shift(pos * scale, Q24_FRAC_BITS);
        s = rnd_shift(t * longint'(gain_reg),
                      Q24_FRAC_BITS + AMP_FRAC_BITS + 1 - SAMPLE_W);
        if (s > SAMPLE_MAX)
        begin
            s = SAMPLE_MAX;
            rail_hits++;
        end
        else if (s < SAMPLE_MIN)
        begin
            s = SAMPLE_MIN;
            rail_hits++;
        end
        return s[SAMPLE_W-1:0];
    endfunction

    // One Euler step; all derivatives come from the state before the step.
    function automatic stereo_pair_t advance_orbit(logic rs);
        longint dx;
        longint dy;
        longint dz;
        longint xc;
        longint dt;
        stereo_pair_t pair;
        if (rs)
        begin
            orb_x = STATE_ONE;
            orb_y = STATE_ONE;
            orb_z = STATE_ONE;
        end
        dx = clamp32(-orb_y - orb_z);
        dy = clamp32(orb_x + rnd_shift(K_A * orb_y, Q24_FRAC_BITS));
        xc = clamp32(orb_x - K_C);
        dz = clamp32(K_B + rnd_shift(xc * orb_z, Q24_FRAC_BITS));
        dt = longint'(dt_reg);
        orb_x = clamp32(orb_x + rnd_shift(dx * dt, DT_W));
        orb_y = clamp32(orb_y + rnd_shift(dy * dt, DT_W));
        orb_z = clamp32(orb_z + rnd_shift(dz * dt, DT_W));
        pair.left  = to_sample(orb_x, longint'(SCALE_LEFT));
        pair.right = mono_reg ? pair.left : to_sample(orb_y, longint'(SCALE_RIGHT));
        return pair;
    endfunction

    task automatic flag_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s", $time, what);
    endtask

    task automatic send_tick(input logic rs);
        if ($urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        in_valid <= 1'b1;
        restart  <= rs;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_pairs.push_back(advance_orbit(rs));
        ticks_sent++;
        if (rs)
            restarts_sent++;
    endtask

    // Holds the sender off until every predicted pair has come out.
    task automatic wait_all_done();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_pairs.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= data;
        @(posedge clk);
        case (idx)
            CFG_STEP_SIZE: dt_reg   = data[DT_W-1:0];
            CFG_AMPLITUDE: gain_reg = data[15:0];
            CFG_MONO_MODE: mono_reg = data[0];
            default: ;
        endcase
        cfg_write_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic test_reset_defaults();
        gap_pct   = 30;
        stall_pct = 10;
        send_tick(1'b0);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b0);
        settings_used++;
    endtask

    task automatic test_register_extremes();
        wait_all_done();
        // With a zero step the state must hold.
        set_reg(CFG_STEP_SIZE, '0);
        send_tick(1'b0);
        send_tick(1'b0);
        wait_all_done();
        // All-ones data: gain above unity, mono on, upper bits masked.
        set_reg(CFG_AMPLITUDE, '1);
        set_reg(CFG_MONO_MODE, '1);
        set_reg(CFG_UNUSED, CFG_W'($urandom()));
        set_reg(CFG_STEP_SIZE, '1);
        send_tick(1'b1);
        repeat (5) send_tick(1'b0);
        wait_all_done();
        set_reg(CFG_AMPLITUDE, '0);
        set_reg(CFG_MONO_MODE, CFG_W'(2));
        send_tick(1'b0);
        send_tick(1'b1);
        wait_all_done();
        set_reg(CFG_AMPLITUDE, CFG_W'(32768));
        set_reg(CFG_STEP_SIZE, CFG_W'(1));
        send_tick(1'b1);
        send_tick(1'b0);
        // Full step again, now in stereo at unity gain, to drive every saturation.
        wait_all_done();
        set_reg(CFG_STEP_SIZE, '1);
        send_tick(1'b1);
        repeat (5) send_tick(1'b0);
        settings_used += 4;
    endtask

    task automatic test_random_orbits();
        logic [CFG_W-1:0] step_val;
        logic [CFG_W-1:0] gain_val;
        for (int phase = 0; phase < 9; phase++)
        begin
            wait_all_done();
            case ($urandom_range(0, 9))
                0: step_val = '0;
                1: step_val = '1;
                2, 3: step_val = CFG_W'($urandom());
                default: step_val = CFG_W'($urandom_range(1, 4000));
            endcase
            if ($urandom_range(0, 3) == 0)
                gain_val = CFG_W'($urandom());
            else
                gain_val = CFG_W'($urandom_range(0, 32768));
            set_reg(CFG_STEP_SIZE, step_val);
            set_reg(CFG_AMPLITUDE, gain_val);
            set_reg(CFG_MONO_MODE, CFG_W'($urandom()));
            if ($urandom_range(0, 2) == 0)
                set_reg(CFG_UNUSED, CFG_W'($urandom()));
            settings_used++;
            gap_pct   = (phase == 4) ? 0 : $urandom_range(5, 40);
            stall_pct = (phase == 6) ? 0 : $urandom_range(2, 25);
            repeat (170)
            begin
                send_tick($urandom_range(0, 99) < 2);
                if ($urandom_range(0, 99) == 0)
                    wait_all_done();
            end
        end
    endtask

    task automatic test_drain_pauses();
        wait_all_done();
        set_reg(CFG_STEP_SIZE, CFG_W'($urandom_range(200, 3000)));
        set_reg(CFG_AMPLITUDE, CFG_W'(32768));
        set_reg(CFG_MONO_MODE, CFG_W'(0));
        settings_used++;
        gap_pct   = 20;
        stall_pct = 15;
        repeat (20)
        begin
            send_tick($urandom_range(0, 9) == 0);
            wait_all_done();
        end
    endtask

    task automatic test_steady_stream();
        wait_all_done();
        set_reg(CFG_STEP_SIZE, STEP_SIZE_RESET);
        set_reg(CFG_AMPLITUDE, AMPLITUDE_RESET);
        set_reg(CFG_MONO_MODE, CFG_W'(MONO_RESET));
        settings_used++;
        gap_pct   = 0;
        stall_pct = 0;
        repeat (200)
            send_tick($urandom_range(0, 99) == 0);
    endtask

    // Output stall in random bursts.
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if ($urandom_range(0, 99) < stall_pct)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : check_pairs
        stereo_pair_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_pairs.size() == 0)
            begin
                flag_mismatch($sformatf("unexpected pair left %0d right %0d",
                                        left_sample, right_sample));
            end
            else
            begin
                want = pending_pairs.pop_front();
                pairs_checked++;
                if (left_sample !== want.left)
                    flag_mismatch($sformatf("pair %0d left_sample: expected %0d, got %0d",
                                            pairs_checked, $signed(want.left),
                                            left_sample));
                if (right_sample !== want.right)
                    flag_mismatch($sformatf("pair %0d right_sample: expected %0d, got %0d",
                                            pairs_checked, $signed(want.right),
                                            right_sample));
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("Timed out with %0d pairs outstanding", pending_pairs.size());
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        restart      <= 1'b0;
        cfg_write_en <= 1'b0;
        cfg_index    <= CFG_STEP_SIZE;
        cfg_data     <= '0;
        orb_x    = STATE_ONE;
        orb_y    = STATE_ONE;
        orb_z    = STATE_ONE;
        dt_reg   = STEP_SIZE_RESET;
        gain_reg = AMPLITUDE_RESET;
        mono_reg = MONO_RESET;
        gap_pct        = 0;
        stall_pct      = 0;
        ticks_sent     = 0;
        restarts_sent  = 0;
        pairs_checked  = 0;
        mismatch_count = 0;
        settings_used  = 0;
        rail_hits      = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_register_extremes();
        test_random_orbits();
        test_drain_pauses();
        test_steady_stream();

        in_valid <= 1'b0;
        drain_cycles = 0;
        while (pending_pairs.size() != 0 && drain_cycles < 4000)
        begin
            @(posedge clk);
            drain_cycles++;
        end
        repeat (24) @(posedge clk);

        $display("Sent %0d sample ticks (%0d with restart) under %0d register settings.",
                 ticks_sent, restarts_sent, settings_used);
        $display("Compared %0d stereo pairs; %0d predicted samples hit the full-scale rail.",
                 pairs_checked, rail_hits);
        if (pending_pairs.size() != 0)
            $display("%0d predicted pairs never came out", pending_pairs.size());
        if (mismatch_count == 0 && pending_pairs.size() == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("%0d mismatches in total", mismatch_count);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/rco_pkg.sv
rtl/rco_mult.sv
rtl/rco_alu.sv
rtl/rossler_chaotic_oscillator.sv
tb/sv/testbench.sv
